### sv/kdl_pkg.sv
// Shared types and constants for the key debounce / lockout reporter.
// No dependencies; imported by every module of the block.
package kdl_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int CODE_W      = 8;
    localparam int LEVELS_W    = 6;
    localparam int NOW_W       = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int INTERVAL_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 1'b1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd10;

    localparam logic [CODE_W-1:0] USAGE_CODE [KEY_SLOTS] =
        '{8'd10, 8'd9, 8'd7, 8'd22, 8'd11, 8'd4};

    typedef struct packed {
        logic key_edge;
        logic catchup;
        logic rep_next;
    } t_lane_status;

endpackage

### sv/kdl_key_lane.sv
// Per-key debounce lane: previous level, last change time, armed and reported bits.
// Depends on kdl_pkg.
module kdl_key_lane #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_update,
    input  logic                              i_level,
    input  logic [TIME_WIDTH-1:0]             i_now,
    input  logic [kdl_pkg::INTERVAL_W-1:0]    i_interval,
    input  logic                              i_active_low,
    output kdl_pkg::t_lane_status             o_status
);
    import kdl_pkg::*;

    logic                  r_prev;
    logic [TIME_WIDTH-1:0] r_last;
    logic                  r_armed;
    logic                  r_rep;

    logic                  pressed;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  expired;
    logic                  key_edge;
    logic                  catchup;
    logic                  accept;

    always_comb begin
        pressed  = i_level ^ i_active_low;
        elapsed  = i_now - r_last;
        expired  = elapsed > {{(TIME_WIDTH-INTERVAL_W){1'b0}}, i_interval};
        key_edge = i_level ^ r_prev;
        catchup  = (r_rep ^ pressed) & expired & r_armed;
        accept   = (key_edge & expired) | catchup;
        o_status.key_edge = key_edge;
        o_status.catchup  = catchup;
        o_status.rep_next = accept ? pressed : r_rep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b1;
            r_last  <= '0;
            r_armed <= 1'b0;
            r_rep   <= 1'b0;
        end else if (i_update) begin
            r_prev <= i_level;
            if (accept) begin
                r_last  <= i_now;
                r_armed <= 1'b1;
                r_rep   <= pressed;
            end
        end
    end

endmodule

### sv/key_debounce_lockout_reporter_unit.sv
// Top level of the key debounce / lockout reporter.
// Depends on kdl_pkg and kdl_key_lane.
// Usage:
//   Slave stream carries one key sample per transfer: tdata[5:0] key levels,
//   tdata[37:6] millisecond timestamp. Master stream returns one report per
//   sample: tdata[0] send_report, then six 8-bit key usage codes.
//   Config port: i_cfg_we with i_cfg_idx 0 writes interval_ms, 1 writes
//   active_low (bit 0). Write only while no sample is in flight.
// Timing:
//   One sample per cycle sustained while the master side takes reports. A
//   sample sits in an input register, is evaluated by the six parallel key
//   lanes (one subtract and compare each) and lands in the output register;
//   lane state updates on the same edge that loads the output register.
// Reset:
//   Synchronous, active low. Both registers empty, interval 10 ms,
//   active-low keys, all keys released and unarmed, timers at zero.
// Stall:
//   While the master side stalls, the report holds; one more sample is
//   taken into the input register, then o_s_axis_tready drops.
module key_debounce_lockout_reporter_unit #(
    parameter int NUM_KEYS   = 6,
    parameter int TIME_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [5:0] key_levels, [37:6] now_ms, [39:38] zero
    input  logic [kdl_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] send_report, [8:1] code_key0 ... [48:41] code_key5, [55:49] zero
    output logic [kdl_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [kdl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kdl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import kdl_pkg::*;

    logic                     r_in_valid;
    logic [IN_TDATA_W-1:0]    r_in_data;
    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;
    logic [INTERVAL_W-1:0]    r_interval;
    logic                     r_active_low;

    logic                     advance;
    logic                     update;
    logic [TIME_WIDTH-1:0]    now;
    t_lane_status             status [KEY_SLOTS];
    logic [OUT_TDATA_W-1:0]   n_out_data;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign update          = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign now             = r_in_data[LEVELS_W +: TIME_WIDTH];

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        if (g < NUM_KEYS) begin : g_on
            kdl_key_lane #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_update     (update),
                .i_level      (r_in_data[g]),
                .i_now        (now),
                .i_interval   (r_interval),
                .i_active_low (r_active_low),
                .o_status     (status[g])
            );
        end else begin : g_off
            assign status[g] = '0;
        end
    end

    always_comb begin
        n_out_data = '0;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            n_out_data[0] = n_out_data[0] | status[k].key_edge | status[k].catchup;
            n_out_data[1 + k*CODE_W +: CODE_W] = status[k].rep_next ? USAGE_CODE[k] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= INTERVAL_RESET;
            r_active_low <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INTERVAL:   r_interval   <= i_cfg_data;
                REG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (update) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

### sv/kdl_checker.sv
// Port-level checks for key_debounce_lockout_reporter_unit, bound to the top level.
// Depends on kdl_pkg.
module kdl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [kdl_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import kdl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("report changed while stalled");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a stalled report");

    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[8:1]   == 8'd0 || o_m_axis_tdata[8:1]   == 8'd10) &&
            (o_m_axis_tdata[16:9]  == 8'd0 || o_m_axis_tdata[16:9]  == 8'd9)  &&
            (o_m_axis_tdata[24:17] == 8'd0 || o_m_axis_tdata[24:17] == 8'd7)  &&
            (o_m_axis_tdata[32:25] == 8'd0 || o_m_axis_tdata[32:25] == 8'd22) &&
            (o_m_axis_tdata[40:33] == 8'd0 || o_m_axis_tdata[40:33] == 8'd11) &&
            (o_m_axis_tdata[48:41] == 8'd0 || o_m_axis_tdata[48:41] == 8'd4))
        else $error("bad usage code in report");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[OUT_TDATA_W-1:49] == '0)
        else $error("report padding not zero");

endmodule

bind key_debounce_lockout_reporter_unit kdl_checker u_kdl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
